### hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// needs clk and arst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define SWA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SWA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/swa_pkg.sv
// shared types, codes and constants of the sliding window average block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package swa_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int SAMPLE_W   = 16;
	localparam int CNT_W      = 7;
	localparam int SHIFT_W    = 3;
	localparam int CFG_W      = 7;
	localparam int IDX_W      = 2;

	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd6;

	// action code of an input transaction
	localparam logic ACT_CLEAR = 1'b1;

	typedef enum logic [IDX_W-1:0] {
		REG_WINDOW_LENGTH = 2'd0,
		REG_AVERAGE_MODE  = 2'd1,
		REG_SHIFT_AMOUNT  = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SUB,
		ST_ADD,
		ST_ABS,
		ST_DIV,
		ST_NEG,
		ST_FIN
	} swa_state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		logic                       action;
		logic signed [SAMPLE_W-1:0] sample;
	} swa_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] average;
		logic [CNT_W-1:0]           fill_level;
	} swa_out_t;

endpackage

`default_nettype wire

### hw/rtl/swa_stream_if.sv
// valid/ready stream channel with a typed payload
// payload types come from swa_pkg
`timescale 1ns / 1ps
`default_nettype none

interface swa_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hw/rtl/swa_alu.sv
// shared add/subtract unit of the averaging datapath
// depends on swa_pkg
`timescale 1ns / 1ps
`default_nettype none

module swa_alu #(
	parameter int Width = 23
) (
	input  swa_pkg::alu_op_t    op,
	input  logic signed [Width-1:0] a,
	input  logic signed [Width-1:0] b,
	output logic signed [Width:0]   y
);
	import swa_pkg::*;

	// one guard bit so the sign of y doubles as a borrow
	always_comb begin
		unique case (op)
			ALU_ADD: y = {a[Width-1], a} + {b[Width-1], b};
			ALU_SUB: y = {a[Width-1], a} - {b[Width-1], b};
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/sliding_window_average_top.sv
// boxcar moving average, one shared adder under a small sequencer
// steps: read the old entry, subtract it, add the new one; divide mode then takes the
// magnitude, divides bit-serially and restores the sign, shift mode shifts the sum, clear
// skips them all; one item in flight, a new transaction is taken only back in idle
// reset: arst_n clears sum, counters, registers but not the window store; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sliding_window_average_top #(
	parameter int MaxWindow = swa_pkg::MAX_WINDOW
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [swa_pkg::IDX_W-1:0]  cfg_index,
	input  logic [swa_pkg::CFG_W-1:0]  cfg_data,
	swa_stream_if.sink                 samples,
	swa_stream_if.source               results
);
	import swa_pkg::*;

	localparam int AW      = $clog2(MaxWindow);
	localparam int HW      = AW + 1;
	localparam int SUM_W   = SAMPLE_W + AW + 1;
	localparam int PW      = ((AW > CNT_W) ? AW : CNT_W) + 1;
	localparam int CNT_MAX = (1 << CNT_W) - 1;
	localparam int LEN_CAP = (MaxWindow > CNT_MAX) ? CNT_MAX : MaxWindow;
	localparam int RW      = CNT_W + 1;
	localparam int DCW     = $clog2(SUM_W);

	// configuration
	logic [CNT_W-1:0]   wl_q;
	logic               mode_q;
	logic [SHIFT_W-1:0] shift_q;

	// window state
	logic signed [SUM_W-1:0] sum_q;
	logic [AW-1:0]           pos_q;
	logic [CNT_W-1:0]        fill_q;
	logic [HW-1:0]           hwm_q;

	// per transaction
	swa_state_t                 state_q, state_d;
	logic signed [SAMPLE_W-1:0] smp_q;
	logic [AW-1:0]              wp_q;
	logic signed [SAMPLE_W-1:0] rd_q;
	logic signed [SUM_W-1:0]    dq_q;
	logic [CNT_W-1:0]           rem_q;
	logic                       neg_q;
	logic [DCW-1:0]             cnt_q;

	// result register
	logic                       out_vld_q;
	logic signed [SAMPLE_W-1:0] out_avg_q;
	logic [CNT_W-1:0]           out_fill_q;

	logic signed [SAMPLE_W-1:0] mem [MaxWindow];

	logic [CNT_W-1:0]        len_eff;
	logic [PW-1:0]           len_ext;
	logic [AW-1:0]           wp;
	logic [PW-1:0]           nxt_pos;
	logic [HW-1:0]           nxt_hwm;
	logic                    old_vld;
	logic [RW-1:0]           trial;
	logic                    ge;
	logic signed [SUM_W-1:0] asr_v;
	logic                    accept;
	logic                    out_free;

	alu_op_t                 alu_op;
	logic signed [SUM_W-1:0] alu_a;
	logic signed [SUM_W-1:0] alu_b;
	logic signed [SUM_W:0]   alu_y;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q    <= CNT_W'(LEN_CAP);
			mode_q  <= 1'b0;
			shift_q <= SHIFT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WINDOW_LENGTH: wl_q    <= cfg_data[CNT_W-1:0];
				REG_AVERAGE_MODE:  mode_q  <= cfg_data[0];
				REG_SHIFT_AMOUNT:  shift_q <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (wl_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (wl_q > CNT_W'(LEN_CAP)) begin
			len_eff = CNT_W'(LEN_CAP);
		end else begin
			len_eff = wl_q;
		end
	end

	assign len_ext  = PW'(len_eff);
	assign wp       = (PW'(pos_q) >= len_ext) ? '0 : pos_q;
	assign nxt_pos  = PW'(wp_q) + PW'(1);
	assign nxt_hwm  = HW'(wp_q) + HW'(1);
	// entries are written as a prefix from zero, so above the high mark they count as zero
	assign old_vld  = HW'(wp_q) < hwm_q;
	assign trial    = {rem_q, dq_q[SUM_W-1]};
	assign ge       = !alu_y[SUM_W];
	assign asr_v    = sum_q >>> shift_q;
	assign accept   = samples.valid && samples.ready;
	assign out_free = !out_vld_q || results.ready;

	swa_alu #(
		.Width(SUM_W)
	) u_alu (
		.op(alu_op),
		.a (alu_a),
		.b (alu_b),
		.y (alu_y)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		samples.ready = 1'b0;
		alu_op        = ALU_ADD;
		alu_a         = sum_q;
		alu_b         = '0;
		unique case (state_q)
			ST_IDLE: begin
				samples.ready = 1'b1;
				if (accept) begin
					state_d = (samples.payload.action == ACT_CLEAR) ? ST_FIN : ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_SUB;
			end
			ST_SUB: begin
				alu_op  = ALU_SUB;
				alu_b   = old_vld ? SUM_W'(rd_q) : '0;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				alu_b   = SUM_W'(smp_q);
				state_d = mode_q ? ST_FIN : ST_ABS;
			end
			ST_ABS: begin
				alu_op  = ALU_SUB;
				alu_a   = '0;
				alu_b   = sum_q;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				alu_op = ALU_SUB;
				alu_a  = SUM_W'(trial);
				alu_b  = SUM_W'(fill_q);
				if (cnt_q == '0) begin
					state_d = ST_NEG;
				end
			end
			ST_NEG: begin
				alu_op  = ALU_SUB;
				alu_a   = '0;
				alu_b   = dq_q;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			pos_q  <= '0;
			fill_q <= '0;
			hwm_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && samples.payload.action == ACT_CLEAR) begin
						sum_q  <= '0;
						pos_q  <= '0;
						fill_q <= '0;
						hwm_q  <= '0;
					end
				end
				ST_SUB: begin
					sum_q <= alu_y[SUM_W-1:0];
				end
				ST_ADD: begin
					sum_q <= alu_y[SUM_W-1:0];
					pos_q <= (nxt_pos >= len_ext) ? '0 : nxt_pos[AW-1:0];
					if (fill_q < len_eff) begin
						fill_q <= fill_q + CNT_W'(1);
					end
					if (nxt_hwm > hwm_q) begin
						hwm_q <= nxt_hwm;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath of one transaction
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					smp_q <= samples.payload.sample;
					wp_q  <= wp;
					dq_q  <= '0;
				end
			end
			ST_ABS: begin
				neg_q <= sum_q[SUM_W-1];
				dq_q  <= sum_q[SUM_W-1] ? alu_y[SUM_W-1:0] : sum_q;
				rem_q <= '0;
				cnt_q <= DCW'(SUM_W - 1);
			end
			ST_DIV: begin
				// restoring divide, one quotient bit per cycle
				rem_q <= ge ? alu_y[CNT_W-1:0] : trial[CNT_W-1:0];
				dq_q  <= {dq_q[SUM_W-2:0], ge};
				cnt_q <= cnt_q - DCW'(1);
			end
			ST_NEG: begin
				if (neg_q) begin
					dq_q <= alu_y[SUM_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// sample store
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q <= mem[wp_q];
		end
		if (state_q == ST_ADD) begin
			mem[wp_q] <= smp_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_avg_q  <= mode_q ? asr_v[SAMPLE_W-1:0] : dq_q[SAMPLE_W-1:0];
			out_fill_q <= fill_q;
		end
	end

	assign results.valid              = out_vld_q;
	assign results.payload.average    = out_avg_q;
	assign results.payload.fill_level = out_fill_q;

	`SWA_ASSERT_ALWAYS(a_pos_in_prefix, HW'(pos_q) <= hwm_q, "write position beyond written prefix")
	`SWA_ASSERT_NEXT(a_div_count, state_q == ST_DIV && cnt_q != '0, state_q == ST_DIV && cnt_q == $past(cnt_q) - DCW'(1), "divide step count broken")
	`SWA_ASSERT_ALWAYS(a_rem_bound, state_q != ST_NEG || rem_q < fill_q, "divide remainder not below divisor")
	`SWA_ASSERT_NEXT(a_clear_state, accept && samples.payload.action == ACT_CLEAR, fill_q == '0 && hwm_q == '0 && sum_q == '0, "clear transaction left window state")

endmodule

`default_nettype wire
